### hw/rtl/lrf_pkg.sv
// Shared types and constants for the line rasterizer and its frame store.
`default_nettype none

package lrf_pkg;

	localparam int SCREEN_WIDTH_DEF  = 84;
	localparam int SCREEN_HEIGHT_DEF = 48;
	localparam int ROWS_PER_BYTE     = 8;
	localparam int ROW_SHIFT         = 3;

	// Field widths
	localparam int PT_W       = 8;   // coordinate field
	localparam int COORD_W    = 10;  // running coordinate, with headroom
	localparam int DELTA_W    = 9;   // doubled absolute delta
	localparam int ACC_W      = 12;  // error accumulator
	localparam int RA_W       = 9;   // read address field
	localparam int BYTE_W     = 8;
	localparam int IN_DATA_W  = 48;

	// s_tdata layout
	localparam int XS_LSB    = 0;
	localparam int YS_LSB    = 8;
	localparam int XE_LSB    = 16;
	localparam int YE_LSB    = 24;
	localparam int COLOR_BIT = 32;
	localparam int RA_LSB    = 33;

	localparam logic REQ_LINE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_FINISH
	} lrf_state_t;

	typedef struct packed {
		logic load;
		logic advance;
	} step_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/line_raster_framebuffer_unit.sv
// Top level: line rasterizer and byte reader over a column-packed frame store.
`default_nettype none

// Draws Bresenham lines into a one-bit frame store of column bytes (eight
// vertical pixels per byte) and reads single bytes back. After reset the
// block zeroes all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) store bytes (504
// at the defaults) before s_tready rises. A read fetches its byte on
// accept. A line visits max(|dx|, |dy|) + 1 pixels; each on-screen pixel
// is a read-modify-write of a frame byte through the store's registered
// read port and write port; off-screen pixels skip the store. Every item
// gives one result: m_tuser high with the byte for a read (zero past the
// end of the store), low with zero data when a line is done. A new item is
// taken while the previous result waits on m_tready.

module line_raster_framebuffer_unit import lrf_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], color[32],
	// read_address[41:33], zero fill [47:42]
	input  logic [IN_DATA_W-1:0] s_tdata,
	// req_type[0]
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// read_data[7:0]
	output logic [BYTE_W-1:0]    m_tdata,
	// was_read[0]
	output logic                 m_tuser
);

	localparam int BYTE_ROWS   = (SCREEN_HEIGHT + ROWS_PER_BYTE - 1) / ROWS_PER_BYTE;
	localparam int STORE_BYTES = SCREEN_WIDTH * BYTE_ROWS;
	localparam int AW          = $clog2(STORE_BYTES);

	lrf_state_t state_q, state_d;

	logic [AW-1:0]         clr_q;
	logic                  color_q, was_read_q, rd_ok_q;
	logic                  out_valid_q, out_was_read_q;
	logic [BYTE_W-1:0]     out_data_q;

	logic                  accept, out_free, clr_last;
	logic                  wr_en, rd_en, out_load, latch_req;
	logic [AW-1:0]         wr_addr, rd_addr, pix_idx;
	logic [BYTE_W-1:0]     wr_data, rd_data, mask;
	logic                  on_screen, rd_ok;
	logic [COORD_W-ROW_SHIFT-1:0] row;
	step_ctrl_t            step_ctrl;
	logic signed [COORD_W-1:0] px, py;
	logic                  step_done;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign clr_last = clr_q == AW'(STORE_BYTES - 1);
	assign rd_ok    = int'(s_tdata[RA_LSB +: RA_W]) < STORE_BYTES;

	// Pixel address and on-screen check from the stepper's position
	always_comb begin
		on_screen = !px[COORD_W-1] && (px < $signed(COORD_W'(SCREEN_WIDTH))) &&
		            !py[COORD_W-1] && (py < $signed(COORD_W'(SCREEN_HEIGHT)));
		row       = py[COORD_W-1:ROW_SHIFT];
		pix_idx   = AW'($unsigned(px)) + AW'(row * SCREEN_WIDTH);
		mask      = BYTE_W'(1) << py[ROW_SHIFT-1:0];
	end

	lrf_step u_step (
		.clk  (clk),
		.ctrl (step_ctrl),
		.xa   (s_tdata[XS_LSB +: PT_W]),
		.ya   (s_tdata[YS_LSB +: PT_W]),
		.xb   (s_tdata[XE_LSB +: PT_W]),
		.yb   (s_tdata[YE_LSB +: PT_W]),
		.px   (px),
		.py   (py),
		.done (step_done)
	);

	lrf_store #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == REQ_READ) ? ST_FINISH : ST_PIX_RD;
				end
			end
			ST_PIX_RD: begin
				if (on_screen) begin
					state_d = ST_PIX_WR;
				end else if (step_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_PIX_WR: begin
				state_d = step_done ? ST_FINISH : ST_PIX_RD;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready          = 1'b0;
		wr_en             = 1'b0;
		wr_addr           = pix_idx;
		wr_data           = color_q ? (rd_data | mask) : (rd_data & ~mask);
		rd_en             = 1'b0;
		rd_addr           = pix_idx;
		step_ctrl.load    = 1'b0;
		step_ctrl.advance = 1'b0;
		out_load          = 1'b0;
		latch_req         = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				latch_req = accept;
				if (accept && s_tuser == REQ_READ) begin
					rd_en   = 1'b1;
					rd_addr = AW'(s_tdata[RA_LSB +: RA_W]);
				end
				step_ctrl.load = accept && (s_tuser == REQ_LINE);
			end
			ST_PIX_RD: begin
				rd_en             = on_screen;
				step_ctrl.advance = !on_screen && !step_done;
			end
			ST_PIX_WR: begin
				wr_en             = 1'b1;
				step_ctrl.advance = !step_done;
			end
			ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_req) begin
			color_q    <= s_tdata[COLOR_BIT];
			was_read_q <= s_tuser == REQ_READ;
			rd_ok_q    <= rd_ok;
		end
		if (out_load) begin
			out_was_read_q <= was_read_q;
			out_data_q     <= (was_read_q && rd_ok_q) ? rd_data : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_was_read_q;

	// A pixel write always follows the read of the same byte
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PIX_WR |-> $past(state_q) == ST_PIX_RD)
		else $error("pixel write without preceding read");

	// Line results carry zero data
	a_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("line result with nonzero data");

	// Once the output is free, a finished item shows up on the output in the next cycle
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("finished item not presented");

	// The store is never written while waiting for an item
	a_idle_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("store write while idle");

endmodule

`default_nettype wire

### hw/rtl/lrf_store.sv
// Frame store: single write port, registered read port.
`default_nettype none

module lrf_store import lrf_pkg::*; #(
	parameter int DEPTH = 504,
	parameter int AW    = 9
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/lrf_step.sv
// Bresenham stepping unit: one pixel step per advance.
`default_nettype none

module lrf_step import lrf_pkg::*; (
	input  logic                      clk,
	input  step_ctrl_t                ctrl,
	input  logic signed [PT_W-1:0]    xa,
	input  logic signed [PT_W-1:0]    ya,
	input  logic signed [PT_W-1:0]    xb,
	input  logic signed [PT_W-1:0]    yb,
	output logic signed [COORD_W-1:0] px,
	output logic signed [COORD_W-1:0] py,
	output logic                      done
);

	localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);

	logic signed [PT_W:0]        dx, dy, adx_full, ady_full;
	logic [DELTA_W-1:0]          ddx, ddy, maj, mnr;
	logic                        shallow;
	logic signed [ACC_W-1:0]     acc0;

	logic signed [COORD_W-1:0]   x_q, y_q;
	logic signed [PT_W-1:0]      xe_q, ye_q;
	logic                        sx_neg_q, sy_neg_q, shallow_q;
	logic [DELTA_W-1:0]          maj_q, mnr_q;
	logic signed [ACC_W-1:0]     acc_q;

	logic                        acc_ge;
	logic signed [COORD_W-1:0]   sx, sy, x_n, y_n;
	logic signed [ACC_W-1:0]     acc_sub, acc_n;

	// Setup: absolute doubled deltas, branch choice, initial error
	always_comb begin
		dx       = {xb[PT_W-1], xb} - {xa[PT_W-1], xa};
		dy       = {yb[PT_W-1], yb} - {ya[PT_W-1], ya};
		adx_full = dx[PT_W] ? -dx : dx;
		ady_full = dy[PT_W] ? -dy : dy;
		ddx      = {adx_full[PT_W-1:0], 1'b0};
		ddy      = {ady_full[PT_W-1:0], 1'b0};
		shallow  = ddx > ddy;
		maj      = shallow ? ddx : ddy;
		mnr      = shallow ? ddy : ddx;
		acc0     = $signed(ACC_W'(mnr)) - $signed(ACC_W'(maj >> 1));
	end

	// Step: one accumulator update, major axis always moves
	always_comb begin
		acc_ge  = !acc_q[ACC_W-1];
		sx      = sx_neg_q ? -ONE : ONE;
		sy      = sy_neg_q ? -ONE : ONE;
		acc_sub = acc_ge ? $signed(ACC_W'(maj_q)) : $signed(ACC_W'(0));
		acc_n   = acc_q + $signed(ACC_W'(mnr_q)) - acc_sub;
		x_n     = (shallow_q || acc_ge) ? x_q + sx : x_q;
		y_n     = (!shallow_q || acc_ge) ? y_q + sy : y_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q       <= COORD_W'(xa);
			y_q       <= COORD_W'(ya);
			xe_q      <= xb;
			ye_q      <= yb;
			sx_neg_q  <= dx[PT_W];
			sy_neg_q  <= dy[PT_W];
			shallow_q <= shallow;
			maj_q     <= maj;
			mnr_q     <= mnr;
			acc_q     <= acc0;
		end else if (ctrl.advance) begin
			x_q   <= x_n;
			y_q   <= y_n;
			acc_q <= acc_n;
		end
	end

	assign px   = x_q;
	assign py   = y_q;
	assign done = shallow_q ? (x_q == COORD_W'(xe_q)) : (y_q == COORD_W'(ye_q));

endmodule

`default_nettype wire
